// ----- hw/rtl/stereo_track_mixer_soft_clip_top_defines.svh -----
// Assertion macros used by the checker module.
`ifndef STEREO_TRACK_MIXER_SOFT_CLIP_TOP_DEFINES_SVH
`define STEREO_TRACK_MIXER_SOFT_CLIP_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define STMSC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define STMSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("check failed");

`endif

// ----- hw/rtl/stmsc_pkg.sv -----
package stmsc_pkg;

  localparam int NUM_TRACKS = 4;
  localparam int NUM_BUS    = 4;
  localparam int SAMPLE_W   = 24;
  localparam int ROUTE_W    = 34;
  localparam int GAIN_W     = 16;
  localparam int MASTER_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_W      = 25;
  localparam int TERM_W     = 42;
  localparam int SUM_W      = 43;
  localparam int MAG_W      = 42;
  localparam int SQ_W       = 56;
  localparam int EN_W       = 28;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 27;
  localparam int DIV_QW     = 40;
  localparam int CLIP_LAT   = DIV_QW + 5;
  localparam int LATENCY    = 3 + 2 * CLIP_LAT + 2;

  localparam int ROUTE_MAIN_BIT = 32;
  localparam int ROUTE_CUE_BIT  = 33;

  localparam logic [MAG_W-1:0] FULL_SCALE =
    MAG_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] CLIP_T =
    MAG_W'(((64'(FULL_SCALE) << 16) * 64'd19) / 64'd20);

  localparam logic [ROUTE_W-1:0]  ROUTE_RESET  = 34'd6442483712;
  localparam logic [MASTER_W-1:0] MASTER_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN   = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTE0 = 3'd0,
    REG_ROUTE1 = 3'd1,
    REG_ROUTE2 = 3'd2,
    REG_ROUTE3 = 3'd3,
    REG_MASTER = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [TERM_W-1:0] main_l;
    logic signed [TERM_W-1:0] main_r;
    logic signed [TERM_W-1:0] cue_l;
    logic signed [TERM_W-1:0] cue_r;
  } term_t;

  typedef struct packed {
    logic neg;
    logic eob;
  } tag_t;

  typedef struct packed {
    logic             valid;
    logic             over;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] e;
    tag_t             tag;
  } clip_side_t;

endpackage

// ----- hw/rtl/stmsc_lane.sv -----
module stmsc_lane (
  input  logic                                   clk_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0]  left_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0]  right_i,
  input  logic        [stmsc_pkg::ROUTE_W-1:0]   route_i,
  output stmsc_pkg::term_t                       terms_o
);
  import stmsc_pkg::*;

  logic [GAIN_W-1:0]        gm, gc;
  logic signed [TERM_W-1:0] sl, sr, gm_s, gc_s;
  term_t                    terms_d, terms_q;

  always_comb begin
    gm = (route_i[GAIN_W-1:0] > UNITY_GAIN) ? UNITY_GAIN : route_i[GAIN_W-1:0];
    gc = (route_i[2*GAIN_W-1:GAIN_W] > UNITY_GAIN) ? UNITY_GAIN
                                                   : route_i[2*GAIN_W-1:GAIN_W];
    sl   = TERM_W'(left_i);
    sr   = TERM_W'(right_i);
    gm_s = TERM_W'({gm, 1'b0});
    gc_s = TERM_W'({gc, 1'b0});
    terms_d = '0;
    if (route_i[ROUTE_MAIN_BIT]) begin
      terms_d.main_l = sl * gm_s;
      terms_d.main_r = sr * gm_s;
    end
    if (route_i[ROUTE_CUE_BIT]) begin
      terms_d.cue_l = sl * gc_s;
      terms_d.cue_r = sr * gc_s;
    end
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

// ----- hw/rtl/stmsc_divider.sv -----
module stmsc_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [stmsc_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [stmsc_pkg::DIV_DEN_W-1:0]     den_i,
  input  stmsc_pkg::clip_side_t               side_i,
  output logic [stmsc_pkg::DIV_QW-1:0]        quo_o,
  output stmsc_pkg::clip_side_t               side_o
);
  import stmsc_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q  [DIV_QW];
  logic [DIV_QW-1:0]    low_q  [DIV_QW];
  logic [DIV_QW-1:0]    quo_q  [DIV_QW];
  logic [DIV_DEN_W-1:0] den_q  [DIV_QW];
  clip_side_t           side_q [DIV_QW];
  logic [DIV_DEN_W:0]   step_d [DIV_QW];

  function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] rem,
                                                  input logic nb,
                                                  input logic [DIV_DEN_W-1:0] den);
    logic [DIV_DEN_W:0] trial;
    trial = {rem, nb};
    if (trial >= {1'b0, den}) begin
      return {1'b1, DIV_DEN_W'(trial - {1'b0, den})};
    end
    return {1'b0, trial[DIV_DEN_W-1:0]};
  endfunction

  always_comb begin
    step_d[0] = div_step(DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_QW]), num_i[DIV_QW-1], den_i);
    for (int k = 1; k < DIV_QW; k++) begin
      step_d[k] = div_step(rem_q[k-1], low_q[k-1][DIV_QW-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= step_d[0][DIV_DEN_W-1:0];
    low_q[0] <= {num_i[DIV_QW-2:0], 1'b0};
    quo_q[0] <= DIV_QW'(step_d[0][DIV_DEN_W]);
    den_q[0] <= den_i;
    for (int k = 1; k < DIV_QW; k++) begin
      rem_q[k] <= step_d[k][DIV_DEN_W-1:0];
      low_q[k] <= {low_q[k-1][DIV_QW-2:0], 1'b0};
      quo_q[k] <= {quo_q[k-1][DIV_QW-2:0], step_d[k][DIV_DEN_W]};
      den_q[k] <= den_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_QW; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= side_i;
      for (int k = 1; k < DIV_QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[DIV_QW-1];
  assign side_o = side_q[DIV_QW-1];

endmodule

// ----- hw/rtl/stmsc_clip.sv -----
module stmsc_clip (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [stmsc_pkg::MAG_W-1:0]    mag_i,
  input  stmsc_pkg::tag_t                tag_i,
  output logic                           valid_o,
  output logic [stmsc_pkg::MAG_W-1:0]    mag_o,
  output stmsc_pkg::tag_t                tag_o
);
  import stmsc_pkg::*;

  localparam logic [SQ_W-1:0] ONE_Q48 = SQ_W'(1) << 48;
  localparam int FS_SH = SAMPLE_W - 1;
  localparam int X_W   = MAG_W + 8;
  localparam int A_W   = X_W - FS_SH;
  localparam int S1_W  = A_W + 1;
  localparam int A2_W  = S1_W - FS_SH;
  localparam int S2_W  = FS_SH + 1;

  logic                 over_a;
  logic [MAG_W-1:0]     e_a;
  clip_side_t           side_a, side_e1_q, side_en_q, side_sq_q, side_den_q, side_c;
  logic [X_W-1:0]       x_a;
  logic [S1_W-1:0]      s1_a, s1_q;
  logic [A_W-1:0]       a_q;
  logic [A2_W-1:0]      a2;
  logic [S2_W-1:0]      s2;
  logic [EN_W-1:0]      en_d, en_q;
  logic [DIV_QW-1:0]    quo_c;
  logic [SQ_W-1:0]      sq_q, den_sum;
  logic [DIV_DEN_W-1:0] den_q;
  logic [MAG_W-1:0]     mag_q;
  tag_t                 tag_q;
  logic                 valid_q;

  always_comb begin
    over_a = mag_i > CLIP_T;
    e_a    = over_a ? (mag_i - CLIP_T) : '0;
    side_a = '{valid: valid_i, over: over_a, mag: mag_i, e: e_a, tag: tag_i};
    x_a    = {e_a, 8'b0};
    s1_a   = S1_W'(x_a[X_W-1:FS_SH]) + S1_W'(x_a[FS_SH-1:0]);
  end

  always_comb begin
    a2   = s1_q[S1_W-1:FS_SH];
    s2   = S2_W'(a2) + S2_W'(s1_q[FS_SH-1:0]);
    en_d = EN_W'(a_q) + EN_W'(a2) + EN_W'(s2 >= S2_W'(FULL_SCALE));
  end

  assign den_sum = ONE_Q48 + sq_q;

  always_ff @(posedge clk_i) begin
    a_q   <= x_a[X_W-1:FS_SH];
    s1_q  <= s1_a;
    en_q  <= en_d;
    sq_q  <= SQ_W'(en_q) * SQ_W'(en_q);
    den_q <= den_sum[54:28];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_e1_q  <= '0;
      side_en_q  <= '0;
      side_sq_q  <= '0;
      side_den_q <= '0;
    end else begin
      side_e1_q  <= side_a;
      side_en_q  <= side_e1_q;
      side_sq_q  <= side_en_q;
      side_den_q <= side_sq_q;
    end
  end

  stmsc_divider u_div_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .num_i  (DIV_NUM_W'({side_den_q.e, 20'b0})),
    .den_i  (den_q),
    .side_i (side_den_q),
    .quo_o  (quo_c),
    .side_o (side_c)
  );

  always_ff @(posedge clk_i) begin
    mag_q <= side_c.over ? (CLIP_T + MAG_W'(quo_c)) : side_c.mag;
    tag_q <= side_c.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_c.valid;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign tag_o   = tag_q;

endmodule

// ----- hw/rtl/stereo_track_mixer_soft_clip_top.sv -----
// Four-track stereo mixer with main and cue buses and a soft clipper before and
// after the master volume. A frame is taken in every cycle that start_i is high
// (busy_o stays low) and its result appears on done_o for one cycle only; the
// receiver cannot stall it, so capture it when done_o is high. Each bus lane
// holds two clippers, each with a two-stage divide by full scale and a 40-stage
// bit-per-stage divider. Configuration writes are taken in every cycle and
// belong in idle periods only.
module stereo_track_mixer_soft_clip_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track0_left_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track0_right_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track1_left_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track1_right_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track2_left_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track2_right_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track3_left_i,
  input  logic signed [stmsc_pkg::SAMPLE_W-1:0] track3_right_i,
  input  logic                                  end_of_block_i,
  output logic                                  done_o,
  output logic signed [stmsc_pkg::OUT_W-1:0]    main_left_o,
  output logic signed [stmsc_pkg::OUT_W-1:0]    main_right_o,
  output logic signed [stmsc_pkg::OUT_W-1:0]    cue_left_o,
  output logic signed [stmsc_pkg::OUT_W-1:0]    cue_right_o,
  output logic                                  block_done_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [stmsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [stmsc_pkg::ROUTE_W-1:0]         cfg_wdata_i
);
  import stmsc_pkg::*;

  logic [ROUTE_W-1:0]         route_q [NUM_TRACKS];
  logic [MASTER_W-1:0]        master_q;
  logic signed [SAMPLE_W-1:0] left_s  [NUM_TRACKS];
  logic signed [SAMPLE_W-1:0] right_s [NUM_TRACKS];
  term_t                      terms   [NUM_TRACKS];
  logic                       valid1_q, valid2_q, valid3_q;
  logic                       eob1_q, eob2_q, eob3_q;
  logic signed [SUM_W-1:0]    sum_d   [NUM_BUS];
  logic signed [SUM_W-1:0]    sum_q   [NUM_BUS];
  logic [MAG_W-1:0]           mag_q   [NUM_BUS];
  logic                       neg_q   [NUM_BUS];
  logic                       c1_valid [NUM_BUS];
  logic [MAG_W-1:0]           c1_mag   [NUM_BUS];
  tag_t                       c1_tag   [NUM_BUS];
  logic [SQ_W-1:0]            prod     [NUM_BUS];
  logic [MAG_W-1:0]           mm_q     [NUM_BUS];
  tag_t                       mtag_q   [NUM_BUS];
  logic                       mvalid_q [NUM_BUS];
  logic                       c2_valid [NUM_BUS];
  logic [MAG_W-1:0]           c2_mag   [NUM_BUS];
  tag_t                       c2_tag   [NUM_BUS];
  logic [OUT_W:0]             q_w      [NUM_BUS];
  logic [OUT_W-1:0]           out_q    [NUM_BUS];
  logic                       done_q, eob_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        route_q[t] <= ROUTE_RESET;
      end
      master_q <= MASTER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROUTE0: route_q[0] <= cfg_wdata_i;
        REG_ROUTE1: route_q[1] <= cfg_wdata_i;
        REG_ROUTE2: route_q[2] <= cfg_wdata_i;
        REG_ROUTE3: route_q[3] <= cfg_wdata_i;
        REG_MASTER: master_q   <= cfg_wdata_i[MASTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign left_s[0]  = track0_left_i;
  assign right_s[0] = track0_right_i;
  assign left_s[1]  = track1_left_i;
  assign right_s[1] = track1_right_i;
  assign left_s[2]  = track2_left_i;
  assign right_s[2] = track2_right_i;
  assign left_s[3]  = track3_left_i;
  assign right_s[3] = track3_right_i;

  for (genvar t = 0; t < NUM_TRACKS; t++) begin : g_lane
    stmsc_lane u_lane (
      .clk_i   (clk_i),
      .left_i  (left_s[t]),
      .right_i (right_s[t]),
      .route_i (route_q[t]),
      .terms_o (terms[t])
    );
  end

  always_comb begin
    for (int b = 0; b < NUM_BUS; b++) begin
      sum_d[b] = '0;
    end
    for (int t = 0; t < NUM_TRACKS; t++) begin
      sum_d[0] = sum_d[0] + SUM_W'(terms[t].main_l);
      sum_d[1] = sum_d[1] + SUM_W'(terms[t].main_r);
      sum_d[2] = sum_d[2] + SUM_W'(terms[t].cue_l);
      sum_d[3] = sum_d[3] + SUM_W'(terms[t].cue_r);
    end
  end

  always_ff @(posedge clk_i) begin
    eob1_q <= end_of_block_i;
    eob2_q <= eob1_q;
    eob3_q <= eob2_q;
    for (int b = 0; b < NUM_BUS; b++) begin
      sum_q[b] <= sum_d[b];
      neg_q[b] <= sum_q[b][SUM_W-1];
      mag_q[b] <= sum_q[b][SUM_W-1] ? MAG_W'(-sum_q[b]) : MAG_W'(sum_q[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= start_i && !busy_o;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  for (genvar b = 0; b < NUM_BUS; b++) begin : g_bus
    stmsc_clip u_clip_pre (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid3_q),
      .mag_i   (mag_q[b]),
      .tag_i   ('{neg: neg_q[b], eob: eob3_q}),
      .valid_o (c1_valid[b]),
      .mag_o   (c1_mag[b]),
      .tag_o   (c1_tag[b])
    );

    assign prod[b] = SQ_W'(c1_mag[b][39:0]) * SQ_W'(master_q);

    always_ff @(posedge clk_i) begin
      mm_q[b]   <= prod[b][SQ_W-1:14];
      mtag_q[b] <= c1_tag[b];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mvalid_q[b] <= 1'b0;
      end else begin
        mvalid_q[b] <= c1_valid[b];
      end
    end

    stmsc_clip u_clip_post (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mvalid_q[b]),
      .mag_i   (mm_q[b]),
      .tag_i   (mtag_q[b]),
      .valid_o (c2_valid[b]),
      .mag_o   (c2_mag[b]),
      .tag_o   (c2_tag[b])
    );

    assign q_w[b] = c2_mag[b][MAG_W-1:16];

    always_ff @(posedge clk_i) begin
      out_q[b] <= c2_tag[b].neg ? OUT_W'(-q_w[b]) : OUT_W'(q_w[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    eob_q <= c2_tag[0].eob;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c2_valid[0] && c2_valid[1] && c2_valid[2] && c2_valid[3];
    end
  end

  assign done_o       = done_q;
  assign main_left_o  = out_q[0];
  assign main_right_o = out_q[1];
  assign cue_left_o   = out_q[2];
  assign cue_right_o  = out_q[3];
  assign block_done_o = eob_q;

endmodule

// ----- hw/rtl/stmsc_checker.sv -----
module stmsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_ready_o
);
  import stmsc_pkg::*;
  `include "stereo_track_mixer_soft_clip_top_defines.svh"

  `STMSC_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)
  `STMSC_ASSERT_ALWAYS(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
  `STMSC_ASSERT_IMP(a_done_has_start, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LATENCY))

endmodule

bind stereo_track_mixer_soft_clip_top stmsc_checker u_stmsc_checker (.*);

// ----- test/stereo_track_mixer_soft_clip_top_tb.sv -----
`timescale 1ns / 1ps

module stereo_track_mixer_soft_clip_top_tb;
  import stmsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint unsigned FS_U   = 64'd8388607;
  localparam longint unsigned THR_U  = (FS_U << 16) * 64'd19 / 64'd20;
  localparam longint unsigned UNITY  = 64'd32768;
  localparam longint CYCLE_LIMIT     = 600000;

  typedef struct packed {
    logic [OUT_W-1:0] main_l;
    logic [OUT_W-1:0] main_r;
    logic [OUT_W-1:0] cue_l;
    logic [OUT_W-1:0] cue_r;
    logic             eob;
  } mix_out_t;

  logic clk_i, rst_ni, start_i, busy_o, end_of_block_i, done_o, block_done_o;
  logic signed [SAMPLE_W-1:0] trk_i [8];
  logic signed [OUT_W-1:0] main_left_o, main_right_o, cue_left_o, cue_right_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ROUTE_W-1:0] cfg_wdata_i;

  logic [ROUTE_W-1:0] route_shadow [4];
  logic [MASTER_W-1:0] master_shadow;
  mix_out_t expected_mix_q [$];
  int errors, idle_pct;
  longint cycles;

  stereo_track_mixer_soft_clip_top uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .track0_left_i(trk_i[0]), .track0_right_i(trk_i[1]),
    .track1_left_i(trk_i[2]), .track1_right_i(trk_i[3]),
    .track2_left_i(trk_i[4]), .track2_right_i(trk_i[5]),
    .track3_left_i(trk_i[6]), .track3_right_i(trk_i[7]),
    .end_of_block_i, .done_o,
    .main_left_o, .main_right_o, .cue_left_o, .cue_right_o, .block_done_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stereo_track_mixer_soft_clip_top");
      $finish;
    end
  end

  function automatic longint unsigned knee_mag(longint unsigned m);
    longint unsigned e, en, den;
    if (m <= THR_U) return m;
    e = m - THR_U;
    en = (e << 8) / FS_U;
    den = ((64'd1 << 48) + en * en) >> 28;
    return THR_U + (e << 20) / den;
  endfunction

  function automatic logic [OUT_W-1:0] bus_output(longint sum);
    logic neg;
    longint unsigned mag, q;
    neg = sum < 0;
    mag = neg ? longint'(-sum) : sum;
    mag = knee_mag(mag);
    mag = (mag * longint'(master_shadow)) >> 14;
    mag = knee_mag(mag);
    q = mag >> 16;
    if (neg) q = 64'd0 - q;
    return q[OUT_W-1:0];
  endfunction

  function automatic mix_out_t mix_frame(logic signed [SAMPLE_W-1:0] s [8], logic eob);
    longint ml, mr, cl, cr;
    longint unsigned gm, gc;
    mix_out_t r;
    ml = 0; mr = 0; cl = 0; cr = 0;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      gm = route_shadow[t][15:0];
      gc = route_shadow[t][31:16];
      if (gm > UNITY) gm = UNITY;
      if (gc > UNITY) gc = UNITY;
      if (route_shadow[t][ROUTE_MAIN_BIT]) begin
        ml += longint'(s[2*t]) * longint'(gm) * 2;
        mr += longint'(s[2*t+1]) * longint'(gm) * 2;
      end
      if (route_shadow[t][ROUTE_CUE_BIT]) begin
        cl += longint'(s[2*t]) * longint'(gc) * 2;
        cr += longint'(s[2*t+1]) * longint'(gc) * 2;
      end
    end
    r.main_l = bus_output(ml);
    r.main_r = bus_output(mr);
    r.cue_l  = bus_output(cl);
    r.cue_r  = bus_output(cr);
    r.eob    = eob;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    mix_out_t want;
    if (rst_ni && done_o) begin
      if (expected_mix_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_mix_q.pop_front();
        if (main_left_o !== want.main_l)
          report_mismatch("main_left", main_left_o, $signed(want.main_l));
        if (main_right_o !== want.main_r)
          report_mismatch("main_right", main_right_o, $signed(want.main_r));
        if (cue_left_o !== want.cue_l)
          report_mismatch("cue_left", cue_left_o, $signed(want.cue_l));
        if (cue_right_o !== want.cue_r)
          report_mismatch("cue_right", cue_right_o, $signed(want.cue_r));
        if (block_done_o !== want.eob)
          report_mismatch("block_done", block_done_o, want.eob);
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ROUTE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < REG_MASTER) route_shadow[idx[1:0]] = val;
    else if (idx == REG_MASTER) master_shadow = val[MASTER_W-1:0];
  endtask

  task automatic drain_mixer();
    start_i <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic send_frame(logic signed [SAMPLE_W-1:0] s [8], logic eob);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    for (int k = 0; k < 8; k++) trk_i[k] <= s[k];
    end_of_block_i <= eob;
    do @(posedge clk_i); while (busy_o);
    expected_mix_q.push_back(mix_frame(s, eob));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [ROUTE_W-1:0] pick_route();
    logic [GAIN_W-1:0] gm, gc;
    gm = ($urandom_range(3) == 0) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(32768, 16000));
    gc = ($urandom_range(3) == 0) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(32768, 16000));
    return {2'($urandom()), gc, gm};
  endfunction

  task automatic send_uniform(logic signed [SAMPLE_W-1:0] v, logic eob);
    logic signed [SAMPLE_W-1:0] s [8];
    foreach (s[k]) s[k] = v;
    send_frame(s, eob);
  endtask

  task automatic send_random(int n);
    logic signed [SAMPLE_W-1:0] s [8];
    repeat (n) begin
      foreach (s[k]) s[k] = pick_sample();
      send_frame(s, 1'($urandom()));
    end
  endtask

  task automatic test_reset_extremes();
    send_uniform({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1);
    send_uniform({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_uniform('0, 1'b1);
    send_uniform(-1, 1'b0);
    send_uniform(SAMPLE_W'(7962000), 1'b0);
    send_random(4);
    drain_mixer();
  endtask

  task automatic test_gain_clamp_and_routes();
    cfg_write(REG_ROUTE0, {2'b11, 16'hFFFF, 16'hFFFF});
    cfg_write(REG_ROUTE1, {2'b00, 16'h8000, 16'h8000});
    cfg_write(REG_ROUTE2, {2'b10, 16'h8001, 16'h0000});
    cfg_write(REG_ROUTE3, {2'b01, 16'h4000, 16'h7FFF});
    cfg_write(REG_MASTER, 34'(16'hFFFF));
    send_uniform({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1);
    send_uniform({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_random(4);
    drain_mixer();
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '0);
    cfg_write(REG_MASTER, '0);
    send_random(3);
    drain_mixer();
    for (int t = 0; t < NUM_TRACKS; t++) cfg_write(reg_idx_e'(t), {2'b00, 32'hFFFF_FFFF});
    cfg_write(REG_MASTER, 34'(16'd16384));
    send_random(3);
    drain_mixer();
  endtask

  task automatic test_random_phase(int pct, int n);
    idle_pct = pct;
    for (int p = 0; p < 3; p++) begin
      for (int t = 0; t < NUM_TRACKS; t++) cfg_write(reg_idx_e'(t), pick_route());
      case (p)
        0: cfg_write(REG_MASTER, 34'(16'hFFFF));
        1: cfg_write(REG_MASTER, 34'($urandom_range(65535)));
        default: cfg_write(REG_MASTER, 34'($urandom_range(20000, 12000)));
      endcase
      send_random(n);
      drain_mixer();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 16;
    rst_ni = 1'b0;
    start_i = 1'b0;
    end_of_block_i = 1'b0;
    foreach (trk_i[k]) trk_i[k] = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ROUTE0;
    cfg_wdata_i = '0;
    foreach (route_shadow[t]) route_shadow[t] = ROUTE_RESET;
    master_shadow = MASTER_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_extremes();
    test_gain_clamp_and_routes();
    test_random_phase(16, 110);
    test_random_phase(46, 110);
    test_random_phase(0, 110);
    if (errors == 0) $display("PASS stereo_track_mixer_soft_clip_top");
    else $display("FAIL stereo_track_mixer_soft_clip_top");
    $finish;
  end
endmodule
